// ===== src/lhps_pkg.sv =====
// Shared types and constants for the LED heartbeat pattern sequencer.
package lhps_pkg;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_START_BOOT = 3'd1,
        OP_FORCE      = 3'd2,
        OP_SET_ENABLE = 3'd3,
        OP_TOGGLE     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CFG_FLASH_ON    = 2'd0,
        CFG_FLASH_GAP   = 2'd1,
        CFG_PERIOD      = 2'd2,
        CFG_BOOT_REPEAT = 2'd3
    } cfg_index_t;

    localparam int unsigned OnW     = 8;
    localparam int unsigned GapW    = 10;
    localparam int unsigned TicksW  = 16;
    localparam int unsigned RepeatW = 4;
    localparam int unsigned StepW   = 3;
    localparam int unsigned CfgDataW = 16;

    localparam logic [StepW-1:0] BootLastStep = 3'd5;
    localparam logic [StepW-1:0] RunLastStep  = 3'd1;

    localparam logic [OnW-1:0]     OnReset     = 8'd3;
    localparam logic [GapW-1:0]    GapReset    = 10'd100;
    localparam logic [TicksW-1:0]  PeriodReset = 16'd1000;
    localparam logic [RepeatW-1:0] RepeatReset = 4'd3;

    // Step durations, already saturated at one tick.
    typedef struct packed {
        logic [OnW-1:0]    on_ticks;
        logic [GapW-1:0]   gap_ticks;
        logic [TicksW-1:0] boot_tail;
        logic [TicksW-1:0] run_tail;
    } step_dur_t;

    typedef struct packed {
        logic running;
        logic enabled;
        logic led;
    } result_t;

endpackage

// ===== src/lhps_cfg_regs.sv =====
// Configuration registers and the derived step durations.
module lhps_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  lhps_pkg::cfg_index_t        wr_index,
    input  logic [lhps_pkg::CfgDataW-1:0] wr_data,
    output lhps_pkg::step_dur_t         dur,
    output logic [lhps_pkg::RepeatW-1:0] boot_repeat
);
    import lhps_pkg::*;

    logic [OnW-1:0]     on_reg;
    logic [GapW-1:0]    gap_reg;
    logic [TicksW-1:0]  period_reg;
    logic [RepeatW-1:0] repeat_reg;
    step_dur_t          dur_reg;
    step_dur_t          dur_next;

    logic [OnW-1:0]  on_sat;
    logic [GapW-1:0] gap_sat;
    logic [18:0]     boot_diff;
    logic [16:0]     run_diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_reg     <= OnReset;
            gap_reg    <= GapReset;
            period_reg <= PeriodReset;
            repeat_reg <= RepeatReset;
        end else if (wr_en) begin
            unique case (wr_index)
                CFG_FLASH_ON:    on_reg     <= wr_data[OnW-1:0];
                CFG_FLASH_GAP:   gap_reg    <= wr_data[GapW-1:0];
                CFG_PERIOD:      period_reg <= wr_data[TicksW-1:0];
                CFG_BOOT_REPEAT: repeat_reg <= wr_data[RepeatW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        on_sat  = (on_reg == '0) ? OnW'(1) : on_reg;
        gap_sat = (gap_reg == '0) ? GapW'(1) : gap_reg;
        boot_diff = {3'b000, period_reg} - {11'b0, on_sat} - {10'b0, on_sat, 1'b0}
                  - {8'b0, gap_sat, 1'b0};
        run_diff  = {1'b0, period_reg} - {9'b0, on_sat};
        dur_next.on_ticks  = on_sat;
        dur_next.gap_ticks = gap_sat;
        dur_next.boot_tail = (boot_diff[18] || boot_diff == '0) ? TicksW'(1)
                                                                : boot_diff[TicksW-1:0];
        dur_next.run_tail  = (run_diff[16] || run_diff == '0) ? TicksW'(1)
                                                              : run_diff[TicksW-1:0];
    end

    // Durations registered from raw regs; user must write only when idle, unenforced.
    always_ff @(posedge aclk) begin
        dur_reg <= dur_next;
    end

    assign dur         = dur_reg;
    assign boot_repeat = repeat_reg;

endmodule

// ===== src/lhps_step_core.sv =====
// Pattern state registers and the per-request next-state logic.
module lhps_step_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            req_fire,
    input  logic [2:0]                      req_op,
    input  logic                            req_flag,
    input  logic [lhps_pkg::RepeatW-1:0]    boot_repeat,
    input  lhps_pkg::step_dur_t             dur,
    output lhps_pkg::result_t               result_next
);
    import lhps_pkg::*;

    logic                 led_reg, led_next;
    logic                 active_reg, active_next;
    logic                 boot_reg, boot_next;
    logic [StepW-1:0]     step_reg, step_next;
    logic [TicksW-1:0]    ticks_reg, ticks_next;
    logic [RepeatW-1:0]   remain_reg, remain_next;
    logic                 enabled_reg, enabled_next;

    logic [RepeatW-1:0]   remain_dec;
    logic [StepW-1:0]     adv_step;
    logic                 adv_boot;
    logic [RepeatW-1:0]   adv_remain;

    function automatic logic [TicksW-1:0] step_len(input logic [StepW-1:0] step,
                                                   input logic boot,
                                                   input step_dur_t d);
        logic [TicksW-1:0] len;
        if (!step[0])
            len = {{(TicksW-OnW){1'b0}}, d.on_ticks};
        else if (boot && step < BootLastStep)
            len = {{(TicksW-GapW){1'b0}}, d.gap_ticks};
        else if (boot)
            len = d.boot_tail;
        else
            len = d.run_tail;
        return len;
    endfunction

    always_comb begin
        remain_dec = remain_reg - RepeatW'(1);
        adv_step   = step_reg + StepW'(1);
        adv_boot   = boot_reg;
        adv_remain = remain_reg;
        if (step_reg == (boot_reg ? BootLastStep : RunLastStep)) begin
            adv_step = '0;
            if (remain_reg != '0) begin
                adv_remain = remain_dec;
                if (remain_dec == '0)
                    adv_boot = 1'b0;
            end
        end
    end

    always_comb begin
        led_next     = led_reg;
        active_next  = active_reg;
        boot_next    = boot_reg;
        step_next    = step_reg;
        ticks_next   = ticks_reg;
        remain_next  = remain_reg;
        enabled_next = enabled_reg;
        unique case (req_op)
            OP_TICK: begin
                if (active_reg) begin
                    if (ticks_reg > TicksW'(1)) begin
                        ticks_next = ticks_reg - TicksW'(1);
                    end else begin
                        step_next   = adv_step;
                        boot_next   = adv_boot;
                        remain_next = adv_remain;
                        led_next    = ~adv_step[0];
                        ticks_next  = step_len(adv_step, adv_boot, dur);
                    end
                end
            end
            OP_START_BOOT: begin
                boot_next   = 1'b1;
                remain_next = boot_repeat;
                step_next   = '0;
                led_next    = 1'b1;
                ticks_next  = step_len('0, 1'b1, dur);
                active_next = 1'b1;
            end
            OP_FORCE: begin
                active_next = 1'b0;
                led_next    = req_flag;
            end
            OP_SET_ENABLE: begin
                if (req_flag != enabled_reg) begin
                    enabled_next = req_flag;
                    if (req_flag) begin
                        boot_next   = 1'b0;
                        remain_next = '0;
                        step_next   = '0;
                        led_next    = 1'b1;
                        ticks_next  = step_len('0, 1'b0, dur);
                        active_next = 1'b1;
                    end else begin
                        active_next = 1'b0;
                        led_next    = 1'b0;
                    end
                end
            end
            OP_TOGGLE: begin
                led_next = ~led_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_reg     <= 1'b1;
            active_reg  <= 1'b0;
            boot_reg    <= 1'b1;
            step_reg    <= '0;
            ticks_reg   <= '0;
            remain_reg  <= '0;
            enabled_reg <= 1'b1;
        end else if (req_fire) begin
            led_reg     <= led_next;
            active_reg  <= active_next;
            boot_reg    <= boot_next;
            step_reg    <= step_next;
            ticks_reg   <= ticks_next;
            remain_reg  <= remain_next;
            enabled_reg <= enabled_next;
        end
    end

    assign result_next.led     = led_next;
    assign result_next.enabled = enabled_next;
    assign result_next.running = active_next;

    a_active_has_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> ticks_reg != '0)
        else $error("step timer running with zero ticks left");

    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= BootLastStep)
        else $error("step number beyond boot pattern");

    a_run_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !boot_reg |-> step_reg <= RunLastStep)
        else $error("run pattern step out of range");

    a_force_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        req_fire && req_op == OP_FORCE |=> !active_reg && led_reg == $past(req_flag))
        else $error("force did not stop the pattern");

endmodule

// ===== src/led_heartbeat_pattern_sequencer.sv =====
// Top level of the LED heartbeat pattern sequencer: request and result registers.
//
//  channel  | direction | payload                               | accept
//  s_axis   | in        | tdata: op[2:0], flag_value[3]         | s_tvalid && s_tready
//  m_axis   | out       | tdata: led, hb_enabled, running [2:0] | m_tvalid && m_tready
//  cfg      | in        | cfg_index[1:0], cfg_data[15:0]        | cfg_valid && cfg_ready
//
// Each request goes from acceptance to result through the input register, then the
// result register; one request per cycle sustained while m_tready stays high.
// Synchronous active-low reset clears both valid flags and the pattern state.
// When the result is stalled, the input register holds one more request and
// s_tready drops only while both are full.
module led_heartbeat_pattern_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] op, [3] flag_value, [7:4] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] led_level, [1] heartbeat_enabled, [2] pattern_running
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lhps_pkg::*;

    logic       in_valid_reg;
    logic [2:0] op_reg;
    logic       flag_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       proceed;
    step_dur_t  dur;
    result_t    result_next;
    logic [RepeatW-1:0] boot_repeat;

    assign proceed   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proceed;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            op_reg   <= s_tdata[2:0];
            flag_reg <= s_tdata[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proceed) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed) begin
            out_reg <= result_next;
        end
    end

    lhps_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (cfg_valid),
        .wr_index    (cfg_index_t'(cfg_index)),
        .wr_data     (cfg_data),
        .dur         (dur),
        .boot_repeat (boot_repeat)
    );

    lhps_step_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_fire    (proceed),
        .req_op      (op_reg),
        .req_flag    (flag_reg),
        .boot_repeat (boot_repeat),
        .dur         (dur),
        .result_next (result_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_reg.running, out_reg.enabled, out_reg.led};

    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !proceed |=> in_valid_reg)
        else $error("pending request dropped");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input not ready while empty");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed |=> m_tvalid)
        else $error("processed request produced no result");

endmodule
